// File: design/qvr_pkg.sv
// Shared widths and word types for the quaternion vector rotator.
package qvr_pkg;

  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned QUAT_WIDTH = 16;

  localparam int unsigned SQ_W  = 2 * QUAT_WIDTH;
  localparam int unsigned D_W   = 2 * QUAT_WIDTH + 1;
  localparam int unsigned A_W   = 2 * QUAT_WIDTH + 2;
  localparam int unsigned PP_W  = QUAT_WIDTH + DATA_WIDTH;
  localparam int unsigned DOT_W = QUAT_WIDTH + DATA_WIDTH + 3;
  localparam int unsigned CR_W  = QUAT_WIDTH + DATA_WIDTH + 1;
  localparam int unsigned W2_W  = QUAT_WIDTH + 2;
  localparam int unsigned PA_W  = A_W + DATA_WIDTH;
  localparam int unsigned PD_W  = DOT_W + QUAT_WIDTH;
  localparam int unsigned PW_W  = W2_W + CR_W;
  localparam int unsigned N_W   = 2 * QUAT_WIDTH + DATA_WIDTH + 5;
  localparam int unsigned R_W   = N_W + 1;

  typedef logic signed [N_W-1:0] num_t;
  typedef logic [D_W-1:0]        den_t;

  typedef struct packed {
    logic                         kind;
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [DATA_WIDTH-1:0] vec_x;
    logic signed [DATA_WIDTH-1:0] vec_y;
    logic signed [DATA_WIDTH-1:0] vec_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] rot_x;
    logic signed [DATA_WIDTH-1:0] rot_y;
    logic signed [DATA_WIDTH-1:0] rot_z;
    logic                         zero_norm;
    logic                         clipped;
  } qvr_out_t;

  typedef struct packed {
    logic zero;
    den_t den;
    num_t num_x;
    num_t num_y;
    num_t num_z;
  } qvr_num_t;

  typedef struct packed {
    logic                  zero;
    logic [2:0]            neg;
    logic [2:0]            clip;
    logic [DATA_WIDTH-1:0] quo_x;
    logic [DATA_WIDTH-1:0] quo_y;
    logic [DATA_WIDTH-1:0] quo_z;
  } qvr_quo_t;

endpackage

// File: design/qvr_prod.sv
// Product pipeline: norm, rotation numerators for the three components.
module qvr_prod (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  qvr_pkg::qvr_in_t data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output qvr_pkg::qvr_num_t data_o
);
  import qvr_pkg::*;

  localparam int unsigned QW = QUAT_WIDTH;
  localparam int unsigned DW = DATA_WIDTH;

  logic [3:0] vld_q;
  logic [3:0] adv;

  logic signed [QW-1:0] u_in [3];
  logic signed [DW-1:0] v_in [3];

  // stage 1
  logic signed [SQ_W-1:0] sq_q [4];
  logic signed [PP_W-1:0] dp_q [3];
  logic signed [PP_W-1:0] cp_q [3];
  logic signed [PP_W-1:0] cm_q [3];
  logic signed [QW-1:0]   u1_q [3];
  logic signed [DW-1:0]   v1_q [3];
  logic signed [QW-1:0]   w1_q;
  logic                   k1_q;

  // stage 2
  den_t                    d2_q;
  logic signed [A_W-1:0]   a2_q;
  logic signed [DOT_W-1:0] dot2_q;
  logic signed [CR_W-1:0]  cr2_q [3];
  logic signed [W2_W-1:0]  w22_q;
  logic signed [QW-1:0]    u2_q [3];
  logic signed [DW-1:0]    v2_q [3];

  // stage 3
  den_t                   d3_q;
  logic signed [PA_W-1:0] pa3_q [3];
  logic signed [PD_W-1:0] pd3_q [3];
  logic signed [PW_W-1:0] pw3_q [3];

  // stage 4
  den_t d4_q;
  num_t n4_q [3];

  assign u_in[0] = data_i.quat_x;
  assign u_in[1] = data_i.quat_y;
  assign u_in[2] = data_i.quat_z;
  assign v_in[0] = data_i.vec_x;
  assign v_in[1] = data_i.vec_y;
  assign v_in[2] = data_i.vec_z;

  assign adv[3]  = !vld_q[3] || !stall_i;
  assign adv[2]  = !vld_q[2] || adv[3];
  assign adv[1]  = !vld_q[1] || adv[2];
  assign adv[0]  = !vld_q[0] || adv[1];
  assign stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      sq_q[0] <= data_i.quat_w * data_i.quat_w;
      for (int l = 0; l < 3; l++) begin
        sq_q[l+1] <= u_in[l] * u_in[l];
        dp_q[l]   <= u_in[l] * v_in[l];
        cp_q[l]   <= u_in[(l+1)%3] * v_in[(l+2)%3];
        cm_q[l]   <= u_in[(l+2)%3] * v_in[(l+1)%3];
        u1_q[l]   <= u_in[l];
        v1_q[l]   <= v_in[l];
      end
      w1_q <= data_i.quat_w;
      k1_q <= data_i.kind;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      d2_q <= D_W'(unsigned'(sq_q[0])) + D_W'(unsigned'(sq_q[1]))
            + D_W'(unsigned'(sq_q[2])) + D_W'(unsigned'(sq_q[3]));
      a2_q <= A_W'(sq_q[0]) - A_W'(sq_q[1]) - A_W'(sq_q[2]) - A_W'(sq_q[3]);
      dot2_q <= (DOT_W'(dp_q[0]) + DOT_W'(dp_q[1]) + DOT_W'(dp_q[2])) <<< 1;
      w22_q <= k1_q ? -(W2_W'(w1_q) <<< 1) : (W2_W'(w1_q) <<< 1);
      for (int l = 0; l < 3; l++) begin
        cr2_q[l] <= CR_W'(cp_q[l]) - CR_W'(cm_q[l]);
        u2_q[l]  <= u1_q[l];
        v2_q[l]  <= v1_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      d3_q <= d2_q;
      for (int l = 0; l < 3; l++) begin
        pa3_q[l] <= a2_q * v2_q[l];
        pd3_q[l] <= dot2_q * u2_q[l];
        pw3_q[l] <= w22_q * cr2_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      d4_q <= d3_q;
      for (int l = 0; l < 3; l++) begin
        n4_q[l] <= N_W'(pa3_q[l]) + N_W'(pd3_q[l]) + N_W'(pw3_q[l]);
      end
    end
  end

  assign valid_o      = vld_q[3];
  assign data_o.zero  = (d4_q == '0);
  assign data_o.den   = d4_q;
  assign data_o.num_x = n4_q[0];
  assign data_o.num_y = n4_q[1];
  assign data_o.num_z = n4_q[2];

endmodule

// File: design/qvr_div.sv
// Rounded restoring divider pipeline, three lanes, one quotient bit per stage.
module qvr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  qvr_pkg::qvr_num_t data_i,
  output logic              valid_o,
  input  logic              stall_i,
  output qvr_pkg::qvr_quo_t data_o
);
  import qvr_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned NS = DW + 3;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  num_t n_in [3];

  // magnitude stage
  logic [N_W-1:0] mag0_q [3];
  logic [2:0]     ng0_q;
  den_t           d0_q;
  logic           zr0_q;

  // rounding offset and limit stage
  logic [R_W-1:0] m1_q [3];
  logic [R_W-1:0] lim1_q [3];
  logic [2:0]     ng1_q;
  den_t           d1_q;
  logic           zr1_q;

  // quotient stages, index 0 holds the range check result
  logic [R_W-1:0] rem_q [DW+1][3];
  logic [DW-1:0]  quo_q [DW+1][3];
  den_t           dv_q  [DW+1];
  logic [2:0]     ng_q  [DW+1];
  logic [2:0]     cl_q  [DW+1];
  logic           zr_q  [DW+1];

  assign n_in[0] = data_i.num_x;
  assign n_in[1] = data_i.num_y;
  assign n_in[2] = data_i.num_z;

  assign adv[NS-1] = !vld_q[NS-1] || !stall_i;
  for (genvar p = 0; p < NS - 1; p++) begin : g_adv
    assign adv[p] = !vld_q[p] || adv[p+1];
  end
  assign stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv[0]) begin
      vld_q[0] <= valid_i;
    end
  end

  for (genvar p = 1; p < NS; p++) begin : g_vld
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[p] <= 1'b0;
      end else if (adv[p]) begin
        vld_q[p] <= vld_q[p-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int l = 0; l < 3; l++) begin
        ng0_q[l]  <= n_in[l][N_W-1];
        mag0_q[l] <= n_in[l][N_W-1] ? (~n_in[l] + N_W'(1)) : n_in[l];
      end
      d0_q  <= data_i.den;
      zr0_q <= data_i.zero;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int l = 0; l < 3; l++) begin
        m1_q[l]   <= R_W'(mag0_q[l]) + R_W'(d0_q >> 1);
        lim1_q[l] <= (R_W'(d0_q) << (DW - 1)) + (ng0_q[l] ? R_W'(d0_q) : R_W'(0));
      end
      ng1_q <= ng0_q;
      d1_q  <= d0_q;
      zr1_q <= zr0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int l = 0; l < 3; l++) begin
        rem_q[0][l] <= m1_q[l];
        quo_q[0][l] <= '0;
        cl_q[0][l]  <= (m1_q[l] >= lim1_q[l]);
      end
      ng_q[0] <= ng1_q;
      dv_q[0] <= d1_q;
      zr_q[0] <= zr1_q;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_bit
    localparam int unsigned BitIdx = DW - 1 - k;
    logic [R_W-1:0] dsh;
    assign dsh = R_W'(dv_q[k]) << BitIdx;

    always_ff @(posedge clk_i) begin
      if (adv[k+3]) begin
        for (int l = 0; l < 3; l++) begin
          if (rem_q[k][l] >= dsh) begin
            rem_q[k+1][l] <= rem_q[k][l] - dsh;
            quo_q[k+1][l] <= quo_q[k][l] | (DW'(1) << BitIdx);
          end else begin
            rem_q[k+1][l] <= rem_q[k][l];
            quo_q[k+1][l] <= quo_q[k][l];
          end
        end
        ng_q[k+1] <= ng_q[k];
        cl_q[k+1] <= cl_q[k];
        dv_q[k+1] <= dv_q[k];
        zr_q[k+1] <= zr_q[k];
      end
    end
  end

  assign valid_o      = vld_q[NS-1];
  assign data_o.zero  = zr_q[DW];
  assign data_o.neg   = ng_q[DW];
  assign data_o.clip  = cl_q[DW];
  assign data_o.quo_x = quo_q[DW][0];
  assign data_o.quo_y = quo_q[DW][1];
  assign data_o.quo_z = quo_q[DW][2];

endmodule

// File: design/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotator: product and divider pipes, output stage.
// Rotates a vector by a quaternion of any nonzero norm, q v q^-1 for kind 0 and
// q^-1 v q for kind 1, dividing by the squared norm with round-half-away rounding
// and saturating each component to the vector width. A zero quaternion returns a
// zero vector with zero_norm set. One word is taken per cycle unless the pipe is
// stalled; each result passes through the product pipe, the restoring divider that
// resolves one quotient bit per stage, and the output register. Stalls on the
// output fill bubbles first, so input keeps flowing until the pipe is full.
module quaternion_vector_rotate (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qvr_pkg::qvr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qvr_pkg::qvr_out_t out_data_o
);
  import qvr_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam logic signed [DW-1:0] MaxVal = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MinVal = {1'b1, {(DW-1){1'b0}}};

  logic     num_valid;
  logic     num_stall;
  qvr_num_t num_data;
  logic     quo_valid;
  logic     quo_stall;
  qvr_quo_t quo_data;

  logic            out_valid_q;
  qvr_out_t        out_data_q;
  qvr_out_t        out_data_d;
  logic            out_adv;
  logic [DW-1:0]   quo [3];
  logic [DW-1:0]   rot [3];

  qvr_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (num_valid),
    .stall_i (num_stall),
    .data_o  (num_data)
  );

  qvr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (num_valid),
    .stall_o (num_stall),
    .data_i  (num_data),
    .valid_o (quo_valid),
    .stall_i (quo_stall),
    .data_o  (quo_data)
  );

  assign out_adv   = !out_valid_q || !out_stall_i;
  assign quo_stall = !out_adv;

  assign quo[0] = quo_data.quo_x;
  assign quo[1] = quo_data.quo_y;
  assign quo[2] = quo_data.quo_z;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (quo_data.zero) begin
        rot[l] = '0;
      end else if (quo_data.clip[l]) begin
        rot[l] = quo_data.neg[l] ? MinVal : MaxVal;
      end else begin
        rot[l] = quo_data.neg[l] ? (~quo[l] + DW'(1)) : quo[l];
      end
    end
    out_data_d.rot_x     = rot[0];
    out_data_d.rot_y     = rot[1];
    out_data_d.rot_z     = rot[2];
    out_data_d.zero_norm = quo_data.zero;
    out_data_d.clipped   = !quo_data.zero && (|quo_data.clip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= quo_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
